// ----- hdl/srtf_pkg.sv -----
// types and constants shared by the srtf tick scheduler
package srtf_pkg;

  localparam int MAX_PROCS = 16;
  localparam int TIME_BITS = 16;
  localparam int IDX_BITS  = $clog2(MAX_PROCS);
  localparam int CNT_BITS  = $clog2(MAX_PROCS + 1);

  localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_TICK  = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NOP   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESULT
  } state_e;

  typedef struct packed {
    action_e              action;
    logic [TIME_BITS-1:0] arrival_time;
    logic [TIME_BITS-1:0] burst_time;
  } req_word_t;

  typedef struct packed {
    logic [IDX_BITS-1:0]  slot_index;
    logic                 idle;
    logic                 new_segment;
    logic [TIME_BITS-1:0] segment_start;
    logic                 finished;
    logic [TIME_BITS-1:0] now_time;
    logic [TIME_BITS-1:0] turnaround;
    logic [TIME_BITS-1:0] waiting;
    logic                 all_done;
    logic                 error;
  } rsp_word_t;

  typedef struct packed {
    logic [TIME_BITS-1:0] arrival;
    logic [TIME_BITS-1:0] burst;
    logic [TIME_BITS-1:0] remaining;
  } entry_t;

endpackage

// ----- hdl/srtf_ram.sv -----
// generic single-write, single-read ram with registered read data
module srtf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/srtf_tick_scheduler_core.sv -----
// srtf tick scheduler top level: process table in ram, scan per tick
//
//   channel | direction | handshake            | word
//   req     | in        | req_valid/req_ready  | req_word_t (action, arrival, burst)
//   rsp     | out       | rsp_valid/rsp_ready  | rsp_word_t (one per request word)
//
// load, clear and no-op go from accept straight to the result state, then to the response register
// tick with entries loaded scans the table first: the table ram has one read port, one entry a cycle
// table entries are written only at the end of an item, never during a scan
// reset and clear empty the table through the counters, the ram is not swept
// a stalled response holds the next result in the result stage; no new word is taken meanwhile
module srtf_tick_scheduler_core
  import srtf_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  req_word_t req,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output rsp_word_t rsp
);

  state_e state, state_next;

  req_word_t item;

  logic [CNT_BITS-1:0]  loaded_count, loaded_count_next;
  logic [CNT_BITS-1:0]  completed_count, completed_count_next;
  logic [TIME_BITS-1:0] cur_time, cur_time_next;
  logic                 prev_none, prev_none_next;
  logic [IDX_BITS:0]    prev_code, prev_code_next;

  logic [CNT_BITS-1:0]  rd_idx;
  logic                 cmp_valid;
  logic [IDX_BITS-1:0]  cmp_idx;
  logic                 best_found;
  logic [IDX_BITS-1:0]  best_idx;
  logic [TIME_BITS-1:0] best_rem;
  logic [TIME_BITS-1:0] best_arr;
  logic [TIME_BITS-1:0] best_bur;

  logic                 ram_we;
  logic [IDX_BITS-1:0]  ram_waddr;
  entry_t               ram_wdata;
  entry_t               ram_rdata;

  logic                 accept;
  logic                 issue;
  logic                 cand_ok;
  logic                 fire;
  logic [TIME_BITS-1:0] time_inc;
  logic [TIME_BITS-1:0] tat;
  logic [IDX_BITS:0]    choice_code;
  rsp_word_t            rsp_next;

  srtf_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(MAX_PROCS)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(rd_idx[IDX_BITS-1:0]),
    .rdata(ram_rdata)
  );

  assign req_ready = (state == ST_IDLE);
  assign accept    = req_valid && req_ready;
  assign issue     = (rd_idx < loaded_count);
  assign fire      = (state == ST_RESULT) && (!rsp_valid || rsp_ready);
  assign time_inc  = (cur_time == TIME_MAX) ? cur_time : cur_time + TIME_BITS'(1);
  assign tat       = time_inc - best_arr;
  assign choice_code = best_found ? {1'b0, best_idx} : {1'b1, {IDX_BITS{1'b0}}};
  assign cand_ok   = (ram_rdata.arrival <= cur_time) && (ram_rdata.remaining != '0) &&
                     (!best_found || (ram_rdata.remaining < best_rem));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next           = state;
    rsp_next             = '0;
    ram_we               = 1'b0;
    ram_waddr            = loaded_count[IDX_BITS-1:0];
    ram_wdata            = '{arrival: item.arrival_time, burst: item.burst_time,
                             remaining: item.burst_time};
    loaded_count_next    = loaded_count;
    completed_count_next = completed_count;
    cur_time_next        = cur_time;
    prev_none_next       = prev_none;
    prev_code_next       = prev_code;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          state_next = (req.action == ACT_TICK && loaded_count != '0) ? ST_SCAN : ST_RESULT;
        end
      end
      ST_SCAN: begin
        if (!issue) begin
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (fire) begin
          state_next = ST_IDLE;
          unique case (item.action)
            ACT_LOAD: begin
              if (loaded_count >= CNT_BITS'(MAX_PROCS) || item.burst_time == '0) begin
                rsp_next.error = 1'b1;
              end else begin
                ram_we              = 1'b1;
                rsp_next.slot_index = loaded_count[IDX_BITS-1:0];
                loaded_count_next   = loaded_count + CNT_BITS'(1);
              end
            end
            ACT_TICK: begin
              if (prev_none || prev_code != choice_code) begin
                rsp_next.new_segment   = 1'b1;
                rsp_next.segment_start = cur_time;
              end
              prev_none_next = 1'b0;
              prev_code_next = choice_code;
              cur_time_next  = time_inc;
              if (!best_found) begin
                rsp_next.idle = 1'b1;
              end else begin
                rsp_next.slot_index = best_idx;
                ram_we              = 1'b1;
                ram_waddr           = best_idx;
                ram_wdata           = '{arrival: best_arr, burst: best_bur,
                                        remaining: best_rem - TIME_BITS'(1)};
                if (best_rem == TIME_BITS'(1)) begin
                  rsp_next.finished    = 1'b1;
                  completed_count_next = completed_count + CNT_BITS'(1);
                  rsp_next.turnaround  = tat;
                  rsp_next.waiting     = (tat >= best_bur) ? tat - best_bur : '0;
                end
              end
            end
            ACT_CLEAR: begin
              loaded_count_next    = '0;
              completed_count_next = '0;
              cur_time_next        = '0;
              prev_none_next       = 1'b1;
              prev_code_next       = '0;
            end
            ACT_NOP: begin
            end
            default: begin
            end
          endcase
          rsp_next.now_time = cur_time_next;
          rsp_next.all_done = (completed_count_next == loaded_count_next);
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded_count    <= '0;
      completed_count <= '0;
      cur_time        <= '0;
      prev_none       <= 1'b1;
      prev_code       <= '0;
      rsp_valid       <= 1'b0;
      cmp_valid       <= 1'b0;
      best_found      <= 1'b0;
      rd_idx          <= '0;
    end else begin
      loaded_count    <= loaded_count_next;
      completed_count <= completed_count_next;
      cur_time        <= cur_time_next;
      prev_none       <= prev_none_next;
      prev_code       <= prev_code_next;
      if (fire) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if (accept) begin
        best_found <= 1'b0;
        cmp_valid  <= 1'b0;
        rd_idx     <= '0;
      end else if (state == ST_SCAN) begin
        if (cmp_valid && cand_ok) begin
          best_found <= 1'b1;
        end
        if (issue) begin
          rd_idx    <= rd_idx + CNT_BITS'(1);
          cmp_valid <= 1'b1;
        end else begin
          cmp_valid <= 1'b0;
        end
      end
    end
  end

  // payload side of the scan and the response register
  always_ff @(posedge clk) begin
    if (accept) begin
      item <= req;
    end
    if (state == ST_SCAN) begin
      cmp_idx <= rd_idx[IDX_BITS-1:0];
      if (cmp_valid && cand_ok) begin
        best_idx <= cmp_idx;
        best_rem <= ram_rdata.remaining;
        best_arr <= ram_rdata.arrival;
        best_bur <= ram_rdata.burst;
      end
    end
    if (fire) begin
      rsp <= rsp_next;
    end
  end

  a_completed_le_loaded: assert property (@(posedge clk) disable iff (rst)
    completed_count <= loaded_count)
    else $error("completed count above loaded count");

  a_loaded_bound: assert property (@(posedge clk) disable iff (rst)
    loaded_count <= CNT_BITS'(MAX_PROCS))
    else $error("loaded count above table size");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> rd_idx <= loaded_count)
    else $error("scan address beyond loaded entries");

  a_write_only_at_result: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> state == ST_RESULT && fire)
    else $error("table write outside the result stage");

  a_finish_not_idle: assert property (@(posedge clk) disable iff (rst)
    fire && rsp_next.finished |=> rsp_valid && !rsp.idle)
    else $error("finished response flagged idle");

endmodule
